>>> hw/rtl/btkk_pkg.sv
`default_nettype none
package btkk_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 64;

  localparam int KEY_W   = 64;
  localparam int POS_W   = 4;
  localparam int OPC_W   = 2;
  localparam int CFG_W   = 5;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DRAIN  = 2'd2
  } opcode_t;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ASC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DESC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_COUNT = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    logic     ascending;
    logic     valid;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

endpackage
`default_nettype wire

>>> hw/rtl/btkk_cell.sv
`default_nettype none
module btkk_cell
  import btkk_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                clk,
  input  wire cell_op_t            op,
  input  wire cell_ctl_t           ctl,
  input  wire logic [KEY_BITS-1:0] new_key,
  input  wire logic [KEY_BITS-1:0] prev_key,
  input  wire logic                keep,
  input  wire logic                prev_keep,
  input  wire logic [KEY_BITS-1:0] next_key,
  output logic      [KEY_BITS-1:0] held_key,
  output logic                     better
);

  logic [KEY_BITS-1:0] held_key_next;

  assign better = ctl.valid &&
                  (ctl.ascending ? (held_key < new_key) : (held_key > new_key));

  always_comb begin
    held_key_next = held_key;
    case (op)
      CELL_INSERT: begin
        // keep: this slot and all ahead of it beat the new key
        // first slot that drops out of that run takes the new key, the tail shifts down
        if (keep) begin
          held_key_next = held_key;
        end else if (prev_keep) begin
          held_key_next = new_key;
        end else begin
          held_key_next = prev_key;
        end
      end
      CELL_ROTATE: begin
        held_key_next = next_key;
      end
      default: begin
        held_key_next = held_key;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    held_key <= held_key_next;
  end

endmodule
`default_nettype wire

>>> hw/rtl/bounded_top_k_key_keeper.sv
`default_nettype none
// Bounded top-k key keeper: sorted list of the best keys of a scan.
// Command channel: start/busy with opcode and key; a transaction is taken on
// an edge with start high and busy low. Clear and insert give no result and
// leave busy low, so a key may be inserted every cycle while no drain runs.
// Drain of n held keys holds busy up to its last result while the cells rotate
// one place per cycle towards cell 0, which feeds the result register; once all
// n keys have passed cell 0 the list is back in place. The first result reaches
// the ports via the state and then the result register, then one per cycle;
// busy falls in the cycle that carries the last one. Each is marked by res_strobe
// for exactly one cycle; the receiver cannot stall them. An empty drain gives
// one result (empty_res and last set) in the cycle after acceptance; busy stays low.
// Configuration (wr_en/wr_index/wr_data) writes limit_mode and limit_count
// directly; write only while idle. Reset empties the list and clears both
// registers; key storage itself is not cleared.
module bounded_top_k_key_keeper
  import btkk_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [OPC_W-1:0]     opcode,
  input  wire logic [KEY_W-1:0]     key,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]     wr_data,
  output logic                      res_strobe,
  output logic      [KEY_W-1:0]     out_key,
  output logic      [POS_W-1:0]     position,
  output logic                      last,
  output logic                      empty_res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [MODE_W-1:0] limit_mode;
  logic [CFG_W-1:0]  limit_count;
  logic [CW-1:0]     held_count, held_count_next;
  logic [IW-1:0]     drain_cnt, drain_cnt_next;
  state_t            state, state_next;

  logic              res_strobe_next, last_next, empty_res_next;
  logic [KEY_W-1:0]  out_key_next;
  logic [POS_W-1:0]  position_next;

  logic [KEY_BITS-1:0] new_key;
  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0]    better;
  logic [DEPTH-1:0]    keep;
  logic [DEPTH-1:0]    valid_vec;
  cell_ctl_t           cell_ctl [DEPTH];
  cell_op_t            cell_op [DEPTH];

  logic          accept, mode_ok, ins_req, ins_hit, ins_write;
  logic [CW-1:0] lim, n_eff;

  assign new_key = key[KEY_BITS-1:0];
  assign busy    = (state == ST_DRAIN);
  assign accept  = start && !busy;

  always_comb begin
    lim     = (32'(limit_count) > DEPTH) ? CW'(DEPTH) : CW'(limit_count);
    n_eff   = (held_count > lim) ? lim : held_count;
    mode_ok = (limit_mode == MODE_ASC) || (limit_mode == MODE_DESC);
    ins_req = accept && (opcode == OP_INSERT) && mode_ok && (lim != '0);
  end

  // some held key drops out of the leading run: the new key finds a slot
  assign ins_hit   = |(valid_vec & ~keep);
  assign ins_write = ins_req && ((n_eff != lim) || ins_hit);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] prev_key_i, next_key_i;
    logic                prev_keep_i;

    assign valid_vec[i] = CW'(i) < n_eff;
    // list may be in the other order after a mode change: only the leading run holds
    assign keep[i]      = &better[i:0];

    if (i == 0) begin : g_head
      assign prev_key_i  = new_key;
      assign prev_keep_i = 1'b1;
    end else begin : g_body
      assign prev_key_i  = cell_key[i-1];
      assign prev_keep_i = keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_key_i = cell_key[0];
    end else begin : g_mid
      // the head entry wraps round to the last held slot during a drain
      assign next_key_i = ((CW'(i) + CW'(1)) == held_count) ? cell_key[0] : cell_key[i+1];
    end

    always_comb begin
      cell_ctl[i].ascending = (limit_mode == MODE_ASC);
      cell_ctl[i].valid     = valid_vec[i];
    end

    always_comb begin
      if (busy && (CW'(i) < held_count)) begin
        cell_op[i] = CELL_ROTATE;
      end else if (ins_write) begin
        cell_op[i] = CELL_INSERT;
      end else begin
        cell_op[i] = CELL_HOLD;
      end
    end

    btkk_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op[i]),
      .ctl        (cell_ctl[i]),
      .new_key    (new_key),
      .prev_key   (prev_key_i),
      .keep       (keep[i]),
      .prev_keep  (prev_keep_i),
      .next_key   (next_key_i),
      .held_key   (cell_key[i]),
      .better     (better[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_mode  <= MODE_NONE;
      limit_count <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_LIMIT_MODE:  limit_mode  <= wr_data[MODE_W-1:0];
        REG_LIMIT_COUNT: limit_count <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    held_count_next = held_count;
    if (accept) begin
      case (opcode)
        OP_CLEAR: begin
          held_count_next = '0;
        end
        OP_INSERT: begin
          if (ins_req) begin
            held_count_next = (n_eff < lim) ? (n_eff + CW'(1)) : lim;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next      = state;
    drain_cnt_next  = drain_cnt;
    res_strobe_next = 1'b0;
    out_key_next    = out_key;
    position_next   = position;
    last_next       = last;
    empty_res_next  = empty_res;
    case (state)
      ST_IDLE: begin
        if (accept && (opcode == OP_DRAIN)) begin
          if (held_count == '0) begin
            res_strobe_next = 1'b1;
            out_key_next    = '0;
            position_next   = '0;
            last_next       = 1'b1;
            empty_res_next  = 1'b1;
          end else begin
            state_next     = ST_DRAIN;
            drain_cnt_next = '0;
          end
        end
      end
      ST_DRAIN: begin
        res_strobe_next = 1'b1;
        out_key_next    = KEY_W'(cell_key[0]);
        position_next   = POS_W'(drain_cnt);
        last_next       = (CW'(drain_cnt) + CW'(1)) == held_count;
        empty_res_next  = 1'b0;
        drain_cnt_next  = drain_cnt + IW'(1);
        if (last_next) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_count <= '0;
      res_strobe <= 1'b0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
      res_strobe <= res_strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    drain_cnt <= drain_cnt_next;
    out_key   <= out_key_next;
    position  <= position_next;
    last      <= last_next;
    empty_res <= empty_res_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(DEPTH))
    else $error("held count beyond store depth");

  a_empty_single: assert property (@(posedge clk) disable iff (rst)
    (res_strobe && empty_res) |-> (last && (position == '0) && (out_key == '0)))
    else $error("empty drain result malformed");

  a_drain_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == OP_DRAIN) && (held_count != '0)) |=> (busy && !res_strobe))
    else $error("drain of a non-empty list did not start");

  a_count_frozen: assert property (@(posedge clk) disable iff (rst)
    busy |=> (held_count == $past(held_count)))
    else $error("held count changed during drain");

endmodule
`default_nettype wire
